>>> src/dtdn_pkg.sv
// types, constants and the month table shared by the day number block
`default_nettype none

package dtdn_pkg;

   localparam int DATE_W  = 27;
   localparam int TAG_W   = 16;
   localparam int DAY_W   = 22;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 7;
   localparam int DOM_W   = 7;
   localparam int CENT_W  = 8;
   localparam int LEAP_W  = 12;
   localparam int MOFF_W  = 9;
   localparam int OFFS_W  = 9;
   localparam int BASE_W  = 24;

   localparam int YEAR_DIV   = 10000;
   localparam int YEAR_RECIP = 109951162;
   localparam int YEAR_SHIFT = 40;
   localparam int HUNDRED    = 100;
   localparam int HUND_RECIP = 5243;
   localparam int HUND_SHIFT = 19;
   localparam int DAYS_YEAR  = 365;
   localparam int FEBRUARY   = 2;
   localparam int DAY_MAX    = 4194303;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic signed [BASE_W-1:0] base;
      logic [OFFS_W-1:0]        offs;
      logic                     first;
   } work_type;

   // days of the months before the given month, nothing for a bad month
   function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [MOFF_W-1:0] offs;
      case (month)
         7'd1:    offs = 9'd0;
         7'd2:    offs = 9'd31;
         7'd3:    offs = 9'd59;
         7'd4:    offs = 9'd90;
         7'd5:    offs = 9'd120;
         7'd6:    offs = 9'd151;
         7'd7:    offs = 9'd181;
         7'd8:    offs = 9'd212;
         7'd9:    offs = 9'd243;
         7'd10:   offs = 9'd273;
         7'd11:   offs = 9'd304;
         7'd12:   offs = 9'd334;
         default: offs = 9'd0;
      endcase
      return offs;
   endfunction

endpackage

`default_nettype wire

>>> src/dtdn_if.sv
// request and response channel interfaces
`default_nettype none

interface dtdn_req_if;
   logic                           valid;
   logic                           ready;
   logic [dtdn_pkg::DATE_W-1:0]    date_code;
   logic [dtdn_pkg::TAG_W-1:0]     person_tag;
   logic                           first_item;

   modport source (output valid, date_code, person_tag, first_item, input ready);
   modport sink (input valid, date_code, person_tag, first_item, output ready);
endinterface

interface dtdn_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dtdn_pkg::DAY_W-1:0]     day_number;
   logic [dtdn_pkg::TAG_W-1:0]     youngest_tag;
   logic [dtdn_pkg::DAY_W-1:0]     youngest_day;
   logic [dtdn_pkg::TAG_W-1:0]     oldest_tag;
   logic [dtdn_pkg::DAY_W-1:0]     oldest_day;

   modport source (output valid, day_number, youngest_tag, youngest_day, oldest_tag,
                   oldest_day, input ready);
   modport sink (input valid, day_number, youngest_tag, youngest_day, oldest_tag,
                 oldest_day, output ready);
endinterface

`default_nettype wire

>>> src/dtdn_front.sv
// front pipeline: splits the decimal date and forms the day count pieces
`default_nettype none

module dtdn_front #(
   parameter int TAG_KEEP = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dtdn_req_if.sink                  req,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output dtdn_pkg::work_type        out_work,
   output logic [TAG_KEEP-1:0]       out_tag
);

   localparam int DateW     = dtdn_pkg::DATE_W;
   localparam int YearW     = dtdn_pkg::YEAR_W;
   localparam int MonthW    = dtdn_pkg::MONTH_W;
   localparam int DomW      = dtdn_pkg::DOM_W;
   localparam int CentW     = dtdn_pkg::CENT_W;
   localparam int LeapW     = dtdn_pkg::LEAP_W;
   localparam int MoffW     = dtdn_pkg::MOFF_W;
   localparam int OffsW     = dtdn_pkg::OFFS_W;
   localparam int BaseW     = dtdn_pkg::BASE_W;
   localparam int ProdW     = 2 * DateW;
   localparam int DivProdW  = 27;
   localparam int BaseProdW = BaseW - 1;

   // stage valids
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic s5_valid_ff, s5_valid_in;
   logic adv1, adv2, adv3, adv4, adv5;

   // stage one
   logic [DateW-1:0]    s1_code_ff, s1_code_in;
   logic [YearW-1:0]    s1_est_ff, s1_est_in;
   logic [TAG_KEEP-1:0] s1_tag_ff;
   logic                s1_first_ff;
   logic [ProdW-1:0]    year_prod;

   // stage two
   logic [YearW-1:0]    s2_year_ff, s2_year_in;
   logic [YearW-1:0]    s2_rem_ff, s2_rem_in;
   logic [TAG_KEEP-1:0] s2_tag_ff;
   logic                s2_first_ff;
   logic [DateW-1:0]    est_scaled;
   logic [DateW-1:0]    rem_raw;

   // stage three
   logic [YearW-1:0]    s3_year_ff;
   logic [YearW-1:0]    s3_rem_ff;
   logic [MonthW-1:0]   s3_month_ff, s3_month_in;
   logic [CentW-1:0]    s3_cent_ff, s3_cent_in;
   logic [TAG_KEEP-1:0] s3_tag_ff;
   logic                s3_first_ff;
   logic [DivProdW-1:0] month_prod;
   logic [DivProdW-1:0] cent_prod;

   // stage four
   logic [YearW-1:0]    s4_n_ff, s4_n_in;
   logic [LeapW-1:0]    s4_leap_days_ff, s4_leap_days_in;
   logic [MoffW-1:0]    s4_moff_ff, s4_moff_in;
   logic [DomW-1:0]     s4_dom_ff, s4_dom_in;
   logic                s4_extra_ff, s4_extra_in;
   logic                s4_year_zero_ff, s4_year_zero_in;
   logic [TAG_KEEP-1:0] s4_tag_ff;
   logic                s4_first_ff;
   logic [YearW-1:0]    cent_years;
   logic                cent_exact;
   logic                leap;
   logic [CentW-1:0]    n_cent;

   // stage five
   dtdn_pkg::work_type  s5_work_ff, s5_work_in;
   logic [TAG_KEEP-1:0] s5_tag_ff;
   logic [BaseProdW-1:0] n_days;

   assign adv5 = !s5_valid_ff || out_ready;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req.ready = adv1;

   always_comb begin
      s1_valid_in = adv1 ? req.valid   : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = adv4 ? s3_valid_ff : s4_valid_ff;
      s5_valid_in = adv5 ? s4_valid_ff : s5_valid_ff;
   end

   // year estimate by reciprocal, at most one short
   always_comb begin
      year_prod  = ProdW'(req.date_code) * ProdW'(dtdn_pkg::YEAR_RECIP);
      s1_code_in = req.date_code;
      s1_est_in  = year_prod[dtdn_pkg::YEAR_SHIFT +: YearW];
   end

   // remainder and one-step correction
   always_comb begin
      est_scaled = DateW'(s1_est_ff) * DateW'(dtdn_pkg::YEAR_DIV);
      rem_raw    = s1_code_ff - est_scaled;
      if (rem_raw >= DateW'(dtdn_pkg::YEAR_DIV)) begin
         s2_year_in = s1_est_ff + YearW'(1);
         s2_rem_in  = YearW'(rem_raw - DateW'(dtdn_pkg::YEAR_DIV));
      end else begin
         s2_year_in = s1_est_ff;
         s2_rem_in  = YearW'(rem_raw);
      end
   end

   // month and century by reciprocal of one hundred
   always_comb begin
      month_prod  = DivProdW'(s2_rem_ff) * DivProdW'(dtdn_pkg::HUND_RECIP);
      cent_prod   = DivProdW'(s2_year_ff) * DivProdW'(dtdn_pkg::HUND_RECIP);
      s3_month_in = month_prod[dtdn_pkg::HUND_SHIFT +: MonthW];
      s3_cent_in  = cent_prod[dtdn_pkg::HUND_SHIFT +: CentW];
   end

   // day of month, leap year and leap days before the year
   always_comb begin
      s4_dom_in       = DomW'(s3_rem_ff - (YearW'(s3_month_ff) * YearW'(dtdn_pkg::HUNDRED)));
      cent_years      = YearW'(s3_cent_ff) * YearW'(dtdn_pkg::HUNDRED);
      cent_exact      = s3_year_ff == cent_years;
      leap            = (s3_year_ff[1:0] == 2'b00) && (!cent_exact || (s3_cent_ff[1:0] == 2'b00));
      s4_n_in         = s3_year_ff - YearW'(1);
      n_cent          = s3_cent_ff - CentW'(cent_exact);
      s4_leap_days_in = LeapW'(s4_n_in >> 2) - LeapW'(n_cent) + LeapW'(n_cent >> 2);
      s4_moff_in      = dtdn_pkg::month_offset(s3_month_ff);
      s4_extra_in     = (s3_month_ff > MonthW'(dtdn_pkg::FEBRUARY)) && leap;
      s4_year_zero_in = s3_year_ff == '0;
   end

   // whole years in days, the rest summed alongside
   always_comb begin
      n_days = BaseProdW'(s4_n_ff) * BaseProdW'(dtdn_pkg::DAYS_YEAR);
      if (s4_year_zero_ff) begin
         s5_work_in.base = -BaseW'(dtdn_pkg::DAYS_YEAR);
      end else begin
         s5_work_in.base = $signed(BaseW'(n_days + BaseProdW'(s4_leap_days_ff)));
      end
      s5_work_in.offs  = OffsW'(s4_moff_ff) + OffsW'(s4_dom_ff) + OffsW'(s4_extra_ff);
      s5_work_in.first = s4_first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_code_ff  <= s1_code_in;
         s1_est_ff   <= s1_est_in;
         s1_tag_ff   <= req.person_tag[TAG_KEEP-1:0];
         s1_first_ff <= req.first_item;
      end
      if (adv2) begin
         s2_year_ff  <= s2_year_in;
         s2_rem_ff   <= s2_rem_in;
         s2_tag_ff   <= s1_tag_ff;
         s2_first_ff <= s1_first_ff;
      end
      if (adv3) begin
         s3_year_ff  <= s2_year_ff;
         s3_rem_ff   <= s2_rem_ff;
         s3_month_ff <= s3_month_in;
         s3_cent_ff  <= s3_cent_in;
         s3_tag_ff   <= s2_tag_ff;
         s3_first_ff <= s2_first_ff;
      end
      if (adv4) begin
         s4_n_ff         <= s4_n_in;
         s4_leap_days_ff <= s4_leap_days_in;
         s4_moff_ff      <= s4_moff_in;
         s4_dom_ff       <= s4_dom_in;
         s4_extra_ff     <= s4_extra_in;
         s4_year_zero_ff <= s4_year_zero_in;
         s4_tag_ff       <= s3_tag_ff;
         s4_first_ff     <= s3_first_ff;
      end
      if (adv5) begin
         s5_work_ff <= s5_work_in;
         s5_tag_ff  <= s4_tag_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_work  = s5_work_ff;
   assign out_tag   = s5_tag_ff;

endmodule

`default_nettype wire

>>> src/dtdn_queue.sv
// short fifo between the front and back pipelines
`default_nettype none

module dtdn_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [DATA_WIDTH-1:0] in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [DATA_WIDTH-1:0]      out_data
);

   localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]     count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = count_ff != CountW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

>>> src/dtdn_back.sv
// back pipeline: final sum with clamping, youngest and oldest tracking
`default_nettype none

module dtdn_back #(
   parameter int TAG_KEEP = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire dtdn_pkg::work_type   in_work,
   input  wire logic [TAG_KEEP-1:0]  in_tag,
   dtdn_rsp_if.source                rsp
);

   localparam int DayW  = dtdn_pkg::DAY_W;
   localparam int BaseW = dtdn_pkg::BASE_W;
   localparam int TagW  = dtdn_pkg::TAG_W;

   logic                    b1_valid_ff, b1_valid_in;
   logic [DayW-1:0]         b1_day_ff, b1_day_in;
   logic [TAG_KEEP-1:0]     b1_tag_ff;
   logic                    b1_first_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [DayW-1:0]         out_day_ff;
   logic [DayW-1:0]         max_day_ff, max_day_in;
   logic [TAG_KEEP-1:0]     max_tag_ff, max_tag_in;
   logic [DayW-1:0]         min_day_ff, min_day_in;
   logic [TAG_KEEP-1:0]     min_tag_ff, min_tag_in;
   logic                    out_adv;
   logic                    b1_adv;
   logic signed [BaseW-1:0] total;

   assign out_adv  = !out_valid_ff || rsp.ready;
   assign b1_adv   = !b1_valid_ff || out_adv;
   assign in_ready = b1_adv;

   // sum and clamp to the day number range
   always_comb begin
      total = in_work.base + $signed(BaseW'(in_work.offs));
      if (total < 0) begin
         b1_day_in = '0;
      end else if (total > $signed(BaseW'(dtdn_pkg::DAY_MAX))) begin
         b1_day_in = DayW'(dtdn_pkg::DAY_MAX);
      end else begin
         b1_day_in = total[DayW-1:0];
      end
   end

   // extremes move only when an item enters the output register
   always_comb begin
      b1_valid_in  = b1_adv ? in_valid : b1_valid_ff;
      out_valid_in = out_adv ? b1_valid_ff : out_valid_ff;
      max_day_in   = max_day_ff;
      max_tag_in   = max_tag_ff;
      min_day_in   = min_day_ff;
      min_tag_in   = min_tag_ff;
      if (out_adv && b1_valid_ff) begin
         if (b1_first_ff) begin
            max_day_in = b1_day_ff;
            max_tag_in = b1_tag_ff;
            min_day_in = b1_day_ff;
            min_tag_in = b1_tag_ff;
         end else if (b1_day_ff > max_day_ff) begin
            max_day_in = b1_day_ff;
            max_tag_in = b1_tag_ff;
         end else if (b1_day_ff < min_day_ff) begin
            min_day_in = b1_day_ff;
            min_tag_in = b1_tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_day_ff   <= '0;
         max_tag_ff   <= '0;
         min_day_ff   <= '0;
         min_tag_ff   <= '0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
         max_day_ff   <= max_day_in;
         max_tag_ff   <= max_tag_in;
         min_day_ff   <= min_day_in;
         min_tag_ff   <= min_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_adv) begin
         b1_day_ff   <= b1_day_in;
         b1_tag_ff   <= in_tag;
         b1_first_ff <= in_work.first;
      end
      if (out_adv) begin
         out_day_ff <= b1_day_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.day_number   = out_day_ff;
   assign rsp.youngest_tag = TagW'(max_tag_ff);
   assign rsp.youngest_day = max_day_ff;
   assign rsp.oldest_tag   = TagW'(min_tag_ff);
   assign rsp.oldest_day   = min_day_ff;

endmodule

`default_nettype wire

>>> src/date_to_day_number_min_max.sv
// Takes one item per clock unless stalled: a decimal YYYYMMDD date, a person tag
// and a first-item flag, and returns one item per input with the proleptic
// Gregorian day number (0001-01-01 is day one, clamped to 0..4194303) and the
// youngest and oldest day numbers with their tags after this item. Throughput is
// one item per cycle when nothing stalls. An item's result passes through eight
// register stages of which the first takes the item: five front stages (reciprocal
// divides by 10000 and 100, leap day count, whole-year multiply), one slot of the
// four-entry queue and two back stages (clamped sum, then the youngest/oldest
// compare into the output register).
// The youngest/oldest compare and update loops through the extreme registers. A
// stalled response side fills the queue before the request side stops. Only the
// low TAG_WIDTH bits of the tag (at most sixteen) are kept.
`default_nettype none

module date_to_day_number_min_max #(
   parameter int TAG_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   dtdn_req_if.sink  req,
   dtdn_rsp_if.source rsp
);

   localparam int TagKeep = (TAG_WIDTH < dtdn_pkg::TAG_W) ? TAG_WIDTH : dtdn_pkg::TAG_W;
   localparam int WorkW   = $bits(dtdn_pkg::work_type);
   localparam int QueueW  = WorkW + TagKeep;

   logic               fr_valid;
   logic               fr_ready;
   dtdn_pkg::work_type fr_work;
   logic [TagKeep-1:0] fr_tag;
   logic [QueueW-1:0]  q_in_data;
   logic [QueueW-1:0]  q_out_data;
   logic               bk_valid;
   logic               bk_ready;
   dtdn_pkg::work_type bk_work;
   logic [TagKeep-1:0] bk_tag;

   dtdn_front #(
      .TAG_KEEP (TagKeep)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_work  (fr_work),
      .out_tag   (fr_tag)
   );

   assign q_in_data = {fr_tag, fr_work};

   dtdn_queue #(
      .DATA_WIDTH (QueueW),
      .DEPTH      (dtdn_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (q_in_data),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (q_out_data)
   );

   assign bk_work = q_out_data[WorkW-1:0];
   assign bk_tag  = q_out_data[QueueW-1:WorkW];

   dtdn_back #(
      .TAG_KEEP (TagKeep)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (bk_valid),
      .in_ready (bk_ready),
      .in_work  (bk_work),
      .in_tag   (bk_tag),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire
